@@ sv/multi_channel_task_watchdog_macros.svh @@
// Assertion macros for the multi-channel task watchdog.
// Used by the top level; depends on clk_i and rst_ni being in scope.
`ifndef MULTI_CHANNEL_TASK_WATCHDOG_MACROS_SVH
`define MULTI_CHANNEL_TASK_WATCHDOG_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while in reset.
`define MCTW_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("watchdog assertion failed");
// Next-cycle implication, disabled while in reset.
`define MCTW_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("watchdog assertion failed");
`else
`define MCTW_ASSERT_IMP(lbl, ante, cons)
`define MCTW_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

@@ sv/mctw_pkg.sv @@
// Package for the multi-channel task watchdog: payload types, codes,
// constants and controller/datapath interface structs. No dependencies.
`default_nettype none

package mctw_pkg;

  localparam int CHANNELS_DEF = 16;
  localparam int MS_W         = 32;
  localparam int RATE_W       = 14;
  localparam int LIMIT_W      = 8;
  localparam int MISS_W       = 8;
  localparam int TICK_W       = 32;
  localparam int WARN_W       = 16;
  localparam int RCH_W        = 4;
  localparam int ID_W         = 8;
  localparam int REM_W        = 10;
  localparam int RECIP_W      = 29;
  localparam int RECIP_SH     = 38;
  localparam int SEC_W        = MS_W + RECIP_W - RECIP_SH;
  localparam int FRAC_W       = REM_W + RATE_W;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = RATE_W;

  localparam logic [REM_W:0]   MS_PER_S       = 11'd1000;
  // Rounded-up 2^38 / 1000; exact quotient for every 32-bit dividend.
  localparam logic [RECIP_W-1:0] RECIP_1000   = 29'h10624DD3;
  localparam logic [MISS_W-1:0] MISS_SAT      = 8'd255;
  localparam logic [RATE_W-1:0] RATE_RESET    = 14'd100;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET  = 8'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_TICK_RATE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MISS_LIMIT = 1'b1;

  typedef enum logic [1:0] {
    OP_TICK     = 2'd0,
    OP_REGISTER = 2'd1,
    OP_FEED     = 2'd2,
    OP_CHECK    = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_DIV,
    ST_REG_WR,
    ST_SCAN_RD,
    ST_SCAN_EV
  } state_e;

  typedef struct packed {
    logic [1:0]      opcode;
    logic [ID_W-1:0] channel_id;
    logic [MS_W-1:0] period_ms;
  } cmd_t;

  typedef struct packed {
    logic              ignored;
    logic [WARN_W-1:0] warn_mask;
    logic              restart;
    logic [RCH_W-1:0]  restart_channel;
  } res_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic tick;
    logic feed;
    logic mul;
    logic div_step;
    logic reg_wr;
    logic scan_init;
    logic scan_next;
    logic scan_eval;
    logic finish;
  } ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_e  op;
    logic oob;
    logic idx_active;
    logic idx_last;
    logic div_done;
    logic hit;
  } stat_t;

endpackage

`default_nettype wire

@@ sv/multi_channel_task_watchdog.sv @@
// Top level of the multi-channel task watchdog: controller plus datapath.
// Depends on mctw_pkg, mctw_ctrl, mctw_dp and the assertion macro header.
//
//   Channel   Ports                                   Transfer
//   command   start_i, busy_o, cmd_i                  start_i high while busy_o low
//   result    result_valid_o, res_o                   one-cycle strobe, cannot stall
//   config    cfg_we_i, cfg_idx_i, cfg_data_i         every edge with cfg_we_i high
//
// A tick, a feed or an out-of-range register is done in the decode state; the
// result strobe follows in the cycle after the last busy cycle, and the next
// command can be taken in that same cycle. A register passes through decode,
// the pipelined millisecond to tick scaling steps and a write of the channel.
// A check decodes, then visits each channel in turn, reading the memories and
// evaluating only the active ones; it ends after the last channel, or earlier
// when a restart ends the scan.
// Reset is asynchronous and clears control state; the channel memories need no
// clearing pass, since a channel is only evaluated once registration has written it.
// The result side cannot stall, so every result is offered for exactly one cycle.
`default_nettype none
`include "multi_channel_task_watchdog_macros.svh"

module multi_channel_task_watchdog #(
  parameter int CHANNELS = mctw_pkg::CHANNELS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start_i,
  output logic                                 busy_o,
  input  wire mctw_pkg::cmd_t                  cmd_i,
  output logic                                 result_valid_o,
  output mctw_pkg::res_t                       res_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [mctw_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [mctw_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import mctw_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  // The controller only sequences and holds just its state register; all other state lives in the datapath.
  mctw_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .stat_i  (stat),
    .ctrl_o  (ctrl),
    .busy_o  (busy_o)
  );

  // The datapath holds the tick counter, configuration, the active flags and
  // the three per-channel memories, and registers the result transfer.
  mctw_dp #(
    .CHANNELS (CHANNELS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .ctrl_i         (ctrl),
    .stat_o         (stat),
    .result_valid_o (result_valid_o),
    .res_o          (res_o)
  );

  // A result can only follow a cycle in which a command was being worked on.
  `MCTW_ASSERT_IMP(a_result_after_busy, result_valid_o, $past(busy_o))
  // An accepted command makes the block busy in the next cycle.
  `MCTW_ASSERT_NXT(a_accept_busy, start_i && !busy_o, busy_o)
  // Without a restart the reported channel is zero.
  `MCTW_ASSERT_IMP(a_rch_zero, result_valid_o && !res_o.restart, res_o.restart_channel == '0)
  // An ignored command never carries check results.
  `MCTW_ASSERT_IMP(a_ignored_clean, result_valid_o && res_o.ignored,
                   (res_o.warn_mask == '0) && !res_o.restart)

endmodule

`default_nettype wire

@@ sv/mctw_ctrl.sv @@
// Controller state machine of the multi-channel task watchdog.
// Depends on mctw_pkg; drives the datapath through ctrl_t.
`default_nettype none

module mctw_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire mctw_pkg::stat_t stat_i,
  output mctw_pkg::ctrl_t     ctrl_o,
  output logic                busy_o
);
  import mctw_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        unique case (stat_i.op)
          OP_TICK:     state_d = ST_IDLE;
          OP_REGISTER: state_d = stat_i.oob ? ST_IDLE : ST_DIV;
          OP_FEED:     state_d = ST_IDLE;
          OP_CHECK:    state_d = ST_SCAN_RD;
        endcase
      end
      ST_DIV: begin
        if (stat_i.div_done) state_d = ST_REG_WR;
      end
      ST_REG_WR: state_d = ST_IDLE;
      ST_SCAN_RD: begin
        priority if (stat_i.idx_active) state_d = ST_SCAN_EV;
        else if (stat_i.idx_last)       state_d = ST_IDLE;
      end
      ST_SCAN_EV: begin
        if (stat_i.hit || stat_i.idx_last) state_d = ST_IDLE;
        else                               state_d = ST_SCAN_RD;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o = '0;
    unique case (state_q)
      ST_IDLE: ctrl_o.load = start_i;
      ST_DECODE: begin
        unique case (stat_i.op)
          OP_TICK: begin
            ctrl_o.tick   = 1'b1;
            ctrl_o.finish = 1'b1;
          end
          OP_REGISTER: begin
            ctrl_o.mul    = !stat_i.oob;
            ctrl_o.finish = stat_i.oob;
          end
          OP_FEED: begin
            ctrl_o.feed   = !stat_i.oob;
            ctrl_o.finish = 1'b1;
          end
          OP_CHECK: ctrl_o.scan_init = 1'b1;
        endcase
      end
      ST_DIV: ctrl_o.div_step = 1'b1;
      ST_REG_WR: begin
        ctrl_o.reg_wr = 1'b1;
        ctrl_o.finish = 1'b1;
      end
      ST_SCAN_RD: begin
        if (!stat_i.idx_active) begin
          ctrl_o.finish    = stat_i.idx_last;
          ctrl_o.scan_next = !stat_i.idx_last;
        end
      end
      ST_SCAN_EV: begin
        ctrl_o.scan_eval = 1'b1;
        ctrl_o.finish    = stat_i.hit || stat_i.idx_last;
        ctrl_o.scan_next = !(stat_i.hit || stat_i.idx_last);
      end
      default: ctrl_o = '0;
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

`default_nettype wire

@@ sv/mctw_dp.sv @@
// Datapath of the multi-channel task watchdog: registers, channel memories,
// timeout scaler and scan evaluation. Depends on mctw_pkg; driven by mctw_ctrl.
`default_nettype none

module mctw_dp #(
  parameter int CHANNELS = mctw_pkg::CHANNELS_DEF
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire mctw_pkg::cmd_t                       cmd_i,
  input  wire logic                                 cfg_we_i,
  input  wire logic [mctw_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [mctw_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  wire mctw_pkg::ctrl_t                      ctrl_i,
  output mctw_pkg::stat_t                           stat_o,
  output logic                                      result_valid_o,
  output mctw_pkg::res_t                            res_o
);
  import mctw_pkg::*;

  localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int DIV_STEPS = 4;
  localparam int CNT_W     = $clog2(DIV_STEPS);
  localparam int SECP_W    = MS_W + RECIP_W;
  localparam int PARTP_W   = FRAC_W + RECIP_W;
  localparam int FRACQ_W   = PARTP_W - RECIP_SH;

  cmd_t               cmd_q;
  logic [TICK_W-1:0]  now_q;
  logic [RATE_W-1:0]  rate_q;
  logic [LIMIT_W-1:0] limit_q;
  logic [CHANNELS-1:0] active_q;
  logic [CH_W-1:0]    idx_q;
  logic [SEC_W-1:0]   sec_q;
  logic [TICK_W-1:0]  prod_q;
  logic [REM_W-1:0]   rem_q;
  logic [FRAC_W-1:0]  part_q;
  logic [FRACQ_W-1:0] frac_q;
  logic [TICK_W-1:0]  quo_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [WARN_W-1:0]  warn_q;
  res_t               res_q;
  logic               res_valid_q;

  logic [TICK_W-1:0]  to_mem [CHANNELS];
  logic [TICK_W-1:0]  lf_mem [CHANNELS];
  logic [MISS_W-1:0]  ms_mem [CHANNELS];
  logic [TICK_W-1:0]  to_rd_q;
  logic [TICK_W-1:0]  lf_rd_q;
  logic [MISS_W-1:0]  ms_rd_q;

  logic [CH_W-1:0]    id_addr;
  logic               oob;
  logic               feed_wr;
  logic [SECP_W-1:0]  sec_prod;
  logic [MS_W-1:0]    sec_ms;
  logic [PARTP_W-1:0] part_prod;
  logic [TICK_W-1:0]  scaled_tk;
  logic [TICK_W-1:0]  elapsed;
  logic               late;
  logic [MISS_W-1:0]  miss_inc;
  logic [MISS_W-1:0]  miss_new;
  logic               hit;
  logic [ID_W-1:0]    idx_ext;
  logic [WARN_W-1:0]  warn_d;
  logic               ms_we;
  logic [CH_W-1:0]    ms_wa;
  logic [MISS_W-1:0]  ms_wd;
  res_t               res_d;

  assign id_addr = cmd_q.channel_id[CH_W-1:0];
  assign oob     = {1'b0, cmd_q.channel_id} >= (ID_W + 1)'(CHANNELS);
  assign feed_wr = ctrl_i.feed && active_q[id_addr];

  // Milliseconds to ticks as whole seconds times the rate plus the share of the
  // leftover milliseconds. Each division by one thousand is a multiply by the
  // rounded-up reciprocal and a shift; the steps fill sec_q, then rem_q and prod_q, part_q, frac_q and quo_q.
  assign sec_prod  = SECP_W'(cmd_q.period_ms) * SECP_W'(RECIP_1000);
  assign sec_ms    = MS_W'(sec_q) * MS_W'(MS_PER_S);
  assign part_prod = PARTP_W'(part_q) * PARTP_W'(RECIP_1000);
  assign scaled_tk = (quo_q == '0) ? TICK_W'(1) : quo_q;

  // Scan evaluation of the channel at idx_q from the registered reads.
  assign elapsed  = now_q - lf_rd_q;
  assign late     = elapsed > to_rd_q;
  assign miss_inc = (ms_rd_q != MISS_SAT) ? ms_rd_q + MISS_W'(1) : ms_rd_q;
  assign miss_new = late ? miss_inc : '0;
  assign hit      = late && (miss_new >= limit_q);
  assign idx_ext  = ID_W'(idx_q);

  always_comb begin
    warn_d = warn_q;
    if (ctrl_i.scan_eval && late && (miss_new == MISS_W'(1)) && (idx_ext < ID_W'(WARN_W))) begin
      warn_d = warn_q | (WARN_W'(1) << idx_ext[RCH_W-1:0]);
    end
  end

  always_comb begin
    ms_we = ctrl_i.reg_wr || feed_wr || ctrl_i.scan_eval;
    ms_wa = ctrl_i.scan_eval ? idx_q : id_addr;
    ms_wd = ctrl_i.scan_eval ? miss_new : '0;
  end

  always_comb begin
    res_d.ignored         = oob && ((op_e'(cmd_q.opcode) == OP_REGISTER) ||
                                    (op_e'(cmd_q.opcode) == OP_FEED));
    res_d.warn_mask       = warn_d;
    res_d.restart         = ctrl_i.scan_eval && hit;
    res_d.restart_channel = (ctrl_i.scan_eval && hit) ? idx_ext[RCH_W-1:0] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q       <= '0;
      rate_q      <= RATE_RESET;
      limit_q     <= LIMIT_RESET;
      active_q    <= '0;
      idx_q       <= '0;
      warn_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= ctrl_i.finish;
      if (cfg_we_i && (cfg_idx_i == CFG_TICK_RATE))  rate_q  <= cfg_data_i[RATE_W-1:0];
      if (cfg_we_i && (cfg_idx_i == CFG_MISS_LIMIT)) limit_q <= cfg_data_i[LIMIT_W-1:0];
      if (ctrl_i.tick)   now_q <= now_q + TICK_W'(1);
      if (ctrl_i.reg_wr) active_q[id_addr] <= 1'b1;
      if (ctrl_i.load)   warn_q <= '0;
      else               warn_q <= warn_d;
      if (ctrl_i.scan_init)      idx_q <= '0;
      else if (ctrl_i.scan_next) idx_q <= idx_q + CH_W'(1);
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) cmd_q <= cmd_i;
    if (ctrl_i.finish) res_q <= res_d;
    if (ctrl_i.mul) begin
      sec_q <= sec_prod[SECP_W-1:RECIP_SH];
      cnt_q <= '0;
    end else if (ctrl_i.div_step) begin
      rem_q  <= REM_W'(cmd_q.period_ms - sec_ms);
      prod_q <= TICK_W'(sec_q) * TICK_W'(rate_q);
      part_q <= FRAC_W'(rem_q) * FRAC_W'(rate_q);
      frac_q <= part_prod[PARTP_W-1:RECIP_SH];
      quo_q  <= prod_q + TICK_W'(frac_q);
      cnt_q  <= cnt_q + CNT_W'(1);
    end
  end

  // Channel memories: one write and one registered read a cycle.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.reg_wr) to_mem[id_addr] <= scaled_tk;
    to_rd_q <= to_mem[idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.reg_wr || feed_wr) lf_mem[id_addr] <= now_q;
    lf_rd_q <= lf_mem[idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (ms_we) ms_mem[ms_wa] <= ms_wd;
    ms_rd_q <= ms_mem[idx_q];
  end

  always_comb begin
    stat_o.op         = op_e'(cmd_q.opcode);
    stat_o.oob        = oob;
    stat_o.idx_active = active_q[idx_q];
    stat_o.idx_last   = (idx_q == CH_W'(CHANNELS - 1));
    stat_o.div_done   = (cnt_q == CNT_W'(DIV_STEPS - 1));
    stat_o.hit        = hit;
  end

  assign result_valid_o = res_valid_q;
  assign res_o          = res_q;

endmodule

`default_nettype wire
